[hdl/assert_macros.svh]
// Assertion helpers used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mbmd_pkg.sv]
package mbmd_pkg;

   // Frame parser position
   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_ADDR  = 3'd1;
   localparam logic [2:0] PH_CTRL  = 3'd2;
   localparam logic [2:0] PH_LEN1  = 3'd3;
   localparam logic [2:0] PH_LEN2  = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;
   localparam logic [2:0] PH_FCS   = 3'd6;
   localparam logic [2:0] PH_CLOSE = 3'd7;

   // Framing bytes
   localparam logic [7:0] FLAG_BYTE = 8'hF9;
   localparam logic [7:0] CTRL_MASK = 8'hEF;   // poll/final bit cleared
   localparam logic [7:0] TYPE_UI   = 8'h03;
   localparam logic [7:0] TYPE_UIH  = 8'hEF;

   localparam int unsigned LEN_W = 15;

   // One result request
   typedef struct packed {
      logic [5:0] channel;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last;
   } result_type;

endpackage

[hdl/mux_basic_mode_deframer.sv]
// Basic-mode multiplexer deframer (receive side).
// req_*: one received link byte per request. rsp_*: one request per payload
// byte of a UI or UIH frame, carrying its channel; rsp_tlast marks the final
// byte of the frame. An empty UI/UIH frame gives a single request with
// rsp_tuser (has_byte) low and rsp_tlast high. Other frame types, the FCS
// and the closing flag are consumed without output.
// An accepted byte is held in the input register, parsed by the parser step,
// and its request is loaded into the output register, from which it is
// presented on rsp_*. Throughput: one byte per cycle while the receiver does
// not stall, as the parser step takes the held byte whenever the output slot is free.
// When the receiver stalls, the output register holds its request and the
// input register holds one more byte; req_tready drops only while both are
// full. Reset (synchronous, active high) empties both registers and returns
// the parser to flag hunting with channel, frame type and counters cleared.
`include "assert_macros.svh"

module mux_basic_mode_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [5:0] channel, [13:6] payload_byte, [15:14] zero
   output logic        rsp_tuser,    // [0] has_byte
   output logic        rsp_tlast     // last
);

   // Input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Parser state
   logic [2:0]                      phase_ff, phase_in;
   logic [5:0]                      chan_ff, chan_in;
   logic                            data_frm_ff, data_frm_in;
   logic [6:0]                      len_low_ff, len_low_in;
   logic [mbmd_pkg::LEN_W-1:0]      left_ff, left_in;

   // Output register
   logic                  out_vld_ff, out_vld_in;
   mbmd_pkg::result_type  out_ff, out_in;

   logic                       step;
   logic                       gen;
   mbmd_pkg::result_type       res;
   logic [mbmd_pkg::LEN_W-1:0] len_val;
   logic                       len_done;
   logic [7:0]                 ctrl_typ;

   // Parse the held byte when the output slot is free or being drained
   assign step       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;

   assign in_vld_in  = req_tvalid ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign in_byte_in = (req_tvalid && req_tready) ? req_tdata : in_byte_ff;

   // One parser step per byte
   always_comb begin
      phase_in    = phase_ff;
      chan_in     = chan_ff;
      data_frm_in = data_frm_ff;
      len_low_in  = len_low_ff;
      left_in     = left_ff;
      gen         = 1'b0;
      res         = '0;
      res.channel = chan_ff;
      len_val     = '0;
      len_done    = 1'b0;
      ctrl_typ    = in_byte_ff & mbmd_pkg::CTRL_MASK;
      unique case (phase_ff)
         mbmd_pkg::PH_HUNT: begin
            if (in_byte_ff == mbmd_pkg::FLAG_BYTE) phase_in = mbmd_pkg::PH_ADDR;
         end
         mbmd_pkg::PH_ADDR: begin
            chan_in  = in_byte_ff[7:2];
            phase_in = mbmd_pkg::PH_CTRL;
         end
         mbmd_pkg::PH_CTRL: begin
            data_frm_in = (ctrl_typ == mbmd_pkg::TYPE_UI) ||
                          (ctrl_typ == mbmd_pkg::TYPE_UIH);
            phase_in    = mbmd_pkg::PH_LEN1;
         end
         mbmd_pkg::PH_LEN1: begin
            len_low_in = in_byte_ff[7:1];
            len_val    = {8'd0, in_byte_ff[7:1]};
            len_done   = in_byte_ff[0];
            if (!in_byte_ff[0]) phase_in = mbmd_pkg::PH_LEN2;
         end
         mbmd_pkg::PH_LEN2: begin
            len_val  = {in_byte_ff, len_low_ff};
            len_done = 1'b1;
         end
         mbmd_pkg::PH_DATA: begin
            gen              = data_frm_ff;
            res.payload_byte = in_byte_ff;
            res.has_byte     = 1'b1;
            res.last         = (left_ff <= mbmd_pkg::LEN_W'(1));
            if (left_ff <= mbmd_pkg::LEN_W'(1)) begin
               left_in  = '0;
               phase_in = mbmd_pkg::PH_FCS;
            end else begin
               left_in = left_ff - mbmd_pkg::LEN_W'(1);
            end
         end
         mbmd_pkg::PH_FCS: begin
            phase_in = mbmd_pkg::PH_CLOSE;
         end
         mbmd_pkg::PH_CLOSE: begin
            phase_in = mbmd_pkg::PH_HUNT;
         end
         default: begin
            phase_in = mbmd_pkg::PH_HUNT;
         end
      endcase
      // Length complete: payload follows, or an empty frame marker
      if (len_done) begin
         left_in = len_val;
         if (len_val != '0) begin
            phase_in = mbmd_pkg::PH_DATA;
         end else begin
            phase_in         = mbmd_pkg::PH_FCS;
            gen              = data_frm_ff;
            res.payload_byte = '0;
            res.has_byte     = 1'b0;
            res.last         = 1'b1;
         end
      end
   end

   // Output register load and drain
   assign out_vld_in = step ? gen : (rsp_tready ? 1'b0 : out_vld_ff);
   assign out_in     = (step && gen) ? res : out_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         phase_ff    <= mbmd_pkg::PH_HUNT;
         chan_ff     <= '0;
         data_frm_ff <= 1'b0;
         len_low_ff  <= '0;
         left_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (step) begin
            phase_ff    <= phase_in;
            chan_ff     <= chan_in;
            data_frm_ff <= data_frm_in;
            len_low_ff  <= len_low_in;
            left_ff     <= left_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_ff.payload_byte, out_ff.channel};
   assign rsp_tuser  = out_ff.has_byte;
   assign rsp_tlast  = out_ff.last;

   // Checks
   `ASSERT_IMPLY(a_marker_is_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast,
                 "empty-frame marker without last")
   `ASSERT_IMPLY(a_data_count, clock, reset, phase_ff == mbmd_pkg::PH_DATA, left_ff != '0,
                 "payload phase with zero bytes left")
   `ASSERT_NEXT(a_hunt_silent, clock, reset, step && phase_ff == mbmd_pkg::PH_HUNT,
                !out_vld_ff, "result produced while hunting for flag")
   `ASSERT_NEXT(a_fcs_to_close, clock, reset, step && phase_ff == mbmd_pkg::PH_FCS,
                phase_ff == mbmd_pkg::PH_CLOSE, "FCS not followed by closing flag")

endmodule
